[sv/indexed_min_heap_unit_defines.svh]
// ----------------------------------------------------------------------------
// Indexed min-heap assertion macros
// Shared assertion forms for the heap unit checkers.
// ----------------------------------------------------------------------------
`ifndef INDEXED_MIN_HEAP_UNIT_DEFINES_SVH
`define INDEXED_MIN_HEAP_UNIT_DEFINES_SVH

// Condition must hold at every edge outside reset.
`define IMH_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define IMH_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[sv/imh_pkg.sv]
// ----------------------------------------------------------------------------
// Indexed min-heap package
// Sizes, status codes and the slot record shared by the heap unit.
// ----------------------------------------------------------------------------
package imh_pkg;

  localparam int CAPACITY  = 64;
  localparam int NUM_IDS   = 64;
  localparam int KEY_WIDTH = 32;

  localparam int ID_W  = $clog2(NUM_IDS);
  localparam int POS_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_REPLACE = 2'd1;
  localparam logic [1:0] OP_REMOVE  = 2'd2;
  localparam logic [1:0] OP_POP     = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_PRESENT = 3'd1;
  localparam logic [2:0] ST_ABSENT  = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [KEY_WIDTH-1:0] key;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // Position map request from the sequencer.
  typedef struct packed {
    logic [ID_W-1:0]  rd_addr;
    logic             wr_en;
    logic [ID_W-1:0]  wr_addr;
    logic [POS_W-1:0] wr_pos;
    logic             clr_en;
    logic [ID_W-1:0]  clr_addr;
  } pm_req_t;

endpackage

[sv/imh_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/imh_posmap.sv]
// ----------------------------------------------------------------------------
// Indexed min-heap position map
// Slot of each id in RAM, presence held in flops cleared by reset.
// ----------------------------------------------------------------------------
module imh_posmap (
  input  logic                      clk,
  input  logic                      rst,
  input  imh_pkg::pm_req_t          req,
  input  logic [imh_pkg::ID_W-1:0]  chk_a,
  input  logic [imh_pkg::ID_W-1:0]  chk_b,
  output logic                      present_a,
  output logic                      present_b,
  output logic [imh_pkg::POS_W-1:0] rd_pos
);
  import imh_pkg::*;

  logic [NUM_IDS-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (req.wr_en) begin
        vld[req.wr_addr] <= 1'b1;
      end
      if (req.clr_en) begin
        vld[req.clr_addr] <= 1'b0;
      end
    end
  end

  assign present_a = vld[chk_a];
  assign present_b = vld[chk_b];

  imh_ram #(.WIDTH(POS_W), .DEPTH(NUM_IDS)) u_pos_ram (
    .clk   (clk),
    .we    (req.wr_en),
    .waddr (req.wr_addr),
    .wdata (req.wr_pos),
    .raddr (req.rd_addr),
    .rdata (rd_pos)
  );

endmodule

[sv/indexed_min_heap_unit.sv]
// ----------------------------------------------------------------------------
// Indexed min-heap unit
// Binary min-heap of (key, id) pairs with an id-to-slot position map.
// ----------------------------------------------------------------------------
// Usage: one transaction on the input channel (in_valid/in_ready) carries an
// opcode (insert, replace, remove, pop), an item id, a key and, for replace,
// the old id. Each produces exactly one result transaction on the output
// channel (out_valid/out_ready): status, the popped item, the front item and
// the entry count after the operation.
// An error or a pop of the last item goes straight to the result; removal
// of the item in the last slot reads that slot first. Otherwise the entry
// sifts up by parent compares, then down by child compares; a pop sifts
// down only. With 64 slots the deepest leaf lies 6 levels below the root.
// Each parent or child compare needs its own registered read from the
// single read port of the slot RAM.
// One operation is worked on at a time; in_ready is high only when idle.
// Reset clears the count and every presence bit of the position map; slot
// contents stay undefined until written. If the receiver stalls, the result
// holds in the output register and a following operation may run to the end
// of its sift, then waits for the output register to drain.
// ----------------------------------------------------------------------------
module indexed_min_heap_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    opcode,
  input  logic [5:0]                    item_id,
  input  logic [31:0]                   item_key,
  input  logic [5:0]                    old_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    status,
  output logic [5:0]                    popped_id,
  output logic [31:0]                   popped_key,
  output logic                          front_valid,
  output logic [5:0]                    front_id,
  output logic [31:0]                   front_key,
  output logic [6:0]                    entry_count
);
  import imh_pkg::*;

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_RPOS  = 4'd2;
  localparam logic [3:0] S_RMRD  = 4'd3;
  localparam logic [3:0] S_LAST  = 4'd4;
  localparam logic [3:0] S_UP    = 4'd5;
  localparam logic [3:0] S_UPCMP = 4'd6;
  localparam logic [3:0] S_DN    = 4'd7;
  localparam logic [3:0] S_DNL   = 4'd8;
  localparam logic [3:0] S_DNR   = 4'd9;
  localparam logic [3:0] S_DNC   = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]           state;
  logic [1:0]           op_q;
  logic [ID_W-1:0]      id_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [ID_W-1:0]      old_q;
  logic [CNT_W-1:0]     cnt;
  logic [POS_W-1:0]     pos;
  logic [POS_W-1:0]     cidx;
  slot_t                cur;
  slot_t                sel;
  slot_t                root;
  logic [2:0]           status_q;
  logic [ID_W-1:0]      pop_id;
  logic [KEY_WIDTH-1:0] pop_key;

  // Slot RAM ports
  logic             s_we;
  logic [POS_W-1:0] s_waddr;
  slot_t            s_wdata;
  logic [POS_W-1:0] s_raddr;
  slot_t            s_rdata;

  // Position map
  pm_req_t          pm;
  logic             pres_id;
  logic             pres_old;
  logic [POS_W-1:0] pm_pos;

  logic [2:0]       chk_status;
  logic [POS_W+1:0] child;
  logic [POS_W+1:0] cnt_x;
  logic [POS_W-1:0] last_slot;
  logic             up_move;
  logic             dn_stop;

  assign cnt_x     = (POS_W + 2)'(cnt);
  assign child     = {1'b0, pos, 1'b1};
  assign last_slot = POS_W'(cnt - 1'b1);
  assign up_move   = cur.key < s_rdata.key;
  assign dn_stop   = cur.key < sel.key;

  imh_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  imh_posmap u_posmap (
    .clk       (clk),
    .rst       (rst),
    .req       (pm),
    .chk_a     (id_q),
    .chk_b     (old_q),
    .present_a (pres_id),
    .present_b (pres_old),
    .rd_pos    (pm_pos)
  );

  // Misuse checks, from the presence flops and the count
  always_comb begin
    chk_status = ST_OK;
    unique case (op_q)
      OP_INSERT: begin
        if (pres_id) chk_status = ST_PRESENT;
        else if (cnt >= CNT_W'(CAPACITY)) chk_status = ST_FULL;
      end
      OP_REPLACE: begin
        if (!pres_old) chk_status = ST_ABSENT;
        else if (pres_id) chk_status = ST_PRESENT;
      end
      OP_REMOVE: begin
        if (!pres_id) chk_status = ST_ABSENT;
      end
      default: begin
        if (cnt == '0) chk_status = ST_EMPTY;
      end
    endcase
  end

  // Memory addressing and write-back
  always_comb begin
    s_we        = 1'b0;
    s_waddr     = pos;
    s_wdata     = cur;
    s_raddr     = '0;
    pm          = '0;
    pm.wr_addr  = cur.id;
    pm.wr_pos   = pos;
    unique case (state)
      S_CHECK: begin
        s_raddr = last_slot;
        if (op_q == OP_REPLACE) begin
          pm.rd_addr = old_q;
        end else begin
          pm.rd_addr = id_q;
        end
        if (chk_status == ST_OK) begin
          priority case (op_q)
            OP_REPLACE: begin
              pm.clr_en   = 1'b1;
              pm.clr_addr = old_q;
            end
            OP_REMOVE: begin
              pm.clr_en   = 1'b1;
              pm.clr_addr = id_q;
            end
            OP_POP: begin
              pm.clr_en   = 1'b1;
              pm.clr_addr = root.id;
            end
            default: ;
          endcase
        end
      end
      S_UP: begin
        s_raddr = (pos - 1'b1) >> 1;
      end
      S_UPCMP: begin
        if (up_move) begin
          s_we       = 1'b1;
          s_wdata    = s_rdata;
          pm.wr_en   = 1'b1;
          pm.wr_addr = s_rdata.id;
        end
      end
      S_DN: begin
        s_raddr = child[POS_W-1:0];
      end
      S_DNL: begin
        s_raddr = cidx + 1'b1;
      end
      S_DNC: begin
        if (!dn_stop) begin
          s_we       = 1'b1;
          s_wdata    = sel;
          pm.wr_en   = 1'b1;
          pm.wr_addr = sel.id;
        end
      end
      S_FIN: begin
        s_we     = 1'b1;
        pm.wr_en = 1'b1;
      end
      default: ;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // Track the root whenever slot 0 is rewritten
      if (s_we && s_waddr == '0) begin
        root <= s_wdata;
      end
      // Drop the result once taken; the output state reloads it itself
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q     <= opcode;
            id_q     <= item_id;
            key_q    <= item_key;
            old_q    <= old_id;
            status_q <= ST_OK;
            pop_id   <= '0;
            pop_key  <= '0;
            state    <= S_CHECK;
          end
        end
        S_CHECK: begin
          cur.id  <= id_q;
          cur.key <= key_q;
          if (chk_status != ST_OK) begin
            status_q <= chk_status;
            state    <= S_OUT;
          end else begin
            unique case (op_q)
              OP_INSERT: begin
                pos   <= POS_W'(cnt);
                cnt   <= cnt + 1'b1;
                state <= S_UP;
              end
              OP_REPLACE: begin
                state <= S_RPOS;
              end
              OP_REMOVE: begin
                cnt   <= cnt - 1'b1;
                state <= S_RMRD;
              end
              default: begin
                pop_id  <= root.id;
                pop_key <= root.key;
                cnt     <= cnt - 1'b1;
                state   <= (cnt == CNT_W'(1)) ? S_OUT : S_LAST;
              end
            endcase
          end
        end
        S_RPOS: begin
          pos   <= pm_pos;
          state <= S_UP;
        end
        S_RMRD: begin
          // Hold the last entry to refill the hole, unless it is the one removed
          pos   <= pm_pos;
          cur   <= s_rdata;
          state <= (s_rdata.id == id_q) ? S_OUT : S_UP;
        end
        S_LAST: begin
          cur   <= s_rdata;
          pos   <= '0;
          state <= S_DN;
        end
        S_UP: begin
          state <= (pos == '0) ? S_DN : S_UPCMP;
        end
        S_UPCMP: begin
          if (up_move) begin
            pos   <= (pos - 1'b1) >> 1;
            state <= S_UP;
          end else begin
            state <= S_DN;
          end
        end
        S_DN: begin
          cidx  <= child[POS_W-1:0];
          state <= (child >= cnt_x) ? S_FIN : S_DNL;
        end
        S_DNL: begin
          sel   <= s_rdata;
          state <= (child + 1'b1 < cnt_x) ? S_DNR : S_DNC;
        end
        S_DNR: begin
          // Take the right child only if strictly smaller
          if (s_rdata.key < sel.key) begin
            sel  <= s_rdata;
            cidx <= cidx + 1'b1;
          end
          state <= S_DNC;
        end
        S_DNC: begin
          if (dn_stop) begin
            state <= S_FIN;
          end else begin
            pos   <= cidx;
            state <= S_DN;
          end
        end
        S_FIN: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= status_q;
            popped_id   <= pop_id;
            popped_key  <= pop_key;
            front_valid <= (cnt != '0);
            front_id    <= (cnt != '0) ? root.id : '0;
            front_key   <= (cnt != '0) ? root.key : '0;
            entry_count <= cnt;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/imh_checker.sv]
// ----------------------------------------------------------------------------
// Indexed min-heap port checker
// Watches the result channel of the heap unit over time.
// ----------------------------------------------------------------------------
`include "indexed_min_heap_unit_defines.svh"

module imh_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [5:0]  popped_id,
  input logic [31:0] popped_key,
  input logic        front_valid,
  input logic [6:0]  entry_count
);
  import imh_pkg::*;

  `IMH_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(entry_count), "result dropped while stalled")
  `IMH_ASSERT_ALWAYS(a_front, !out_valid || (front_valid == (entry_count != 7'd0)), "front flag disagrees with count")
  `IMH_ASSERT_ALWAYS(a_err_pop, !out_valid || status == ST_OK || (popped_id == 6'd0 && popped_key == 32'd0), "popped fields set on error")
  `IMH_ASSERT_ALWAYS(a_empty, !out_valid || status != ST_EMPTY || entry_count == 7'd0, "empty status with items")

endmodule

bind indexed_min_heap_unit imh_checker u_imh_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .popped_id   (popped_id),
  .popped_key  (popped_key),
  .front_valid (front_valid),
  .entry_count (entry_count)
);

[bench/indexed_min_heap_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indexed min-heap unit testbench
// Drives insert, replace, remove and pop transactions through the valid/ready
// channels with random idling on both sides. A local copy of the heap and
// its id-to-slot map predicts every result, and a small scoreboard compares
// each result transaction field by field.
// ----------------------------------------------------------------------------
module indexed_min_heap_unit_tb;
  import imh_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  popped_id;
    logic [31:0] popped_key;
    logic        front_valid;
    logic [5:0]  front_id;
    logic [31:0] front_key;
    logic [6:0]  entry_count;
  } heap_result_t;

  localparam logic [6:0] POS_NONE = 7'h7f;
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_OPS = 1730;

  // Result checker: holds predicted results in acceptance order.
  class heap_scoreboard;
    heap_result_t pending_q[$];
    int errors;
    int checked;

    function void note_input(heap_result_t r);
      pending_q.push_back(r);
    endfunction

    function void check_result(heap_result_t got);
      heap_result_t want;
      if (pending_q.size() == 0) begin
        $error("result with nothing outstanding");
        errors++;
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (got.status !== want.status) begin
        $error("status exp %0d got %0d", want.status, got.status); errors++;
      end
      if (got.popped_id !== want.popped_id) begin
        $error("popped_id exp %0d got %0d", want.popped_id, got.popped_id); errors++;
      end
      if (got.popped_key !== want.popped_key) begin
        $error("popped_key exp %0h got %0h", want.popped_key, got.popped_key); errors++;
      end
      if (got.front_valid !== want.front_valid) begin
        $error("front_valid exp %0d got %0d", want.front_valid, got.front_valid); errors++;
      end
      if (got.front_id !== want.front_id) begin
        $error("front_id exp %0d got %0d", want.front_id, got.front_id); errors++;
      end
      if (got.front_key !== want.front_key) begin
        $error("front_key exp %0h got %0h", want.front_key, got.front_key); errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count exp %0d got %0d", want.entry_count, got.entry_count); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] opcode = OP_INSERT;
  logic [5:0] item_id = '0;
  logic [31:0] item_key = '0;
  logic [5:0] old_id = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status;
  logic [5:0] popped_id;
  logic [31:0] popped_key;
  logic front_valid;
  logic [5:0] front_id;
  logic [31:0] front_key;
  logic [6:0] entry_count;

  indexed_min_heap_unit u_dut (.*);

  always #6 clk = ~clk;

  // Shadow heap state.
  logic [31:0] heap_key [CAPACITY];
  logic [5:0]  heap_id [CAPACITY];
  logic [6:0]  slot_of [NUM_IDS];
  int          heap_fill;

  heap_scoreboard sb;
  int  idle_cycles;
  bit  timed_out;
  bit  sink_quiet; // hold out_ready high continuously for a stretch
  int  sink_hold;  // cycles left in a long receiver stall
  int  accepted;

  function automatic void place(int pos, logic [5:0] id, logic [31:0] key);
    heap_key[pos] = key;
    heap_id[pos] = id;
    slot_of[id] = pos[6:0];
  endfunction

  function automatic void sink_down(int pos, logic [5:0] id, logic [31:0] key);
    int c;
    forever begin
      c = pos * 2 + 1;
      if (c >= heap_fill) break;
      if (c + 1 < heap_fill && heap_key[c+1] < heap_key[c]) c++;
      if (key < heap_key[c]) break;
      place(pos, heap_id[c], heap_key[c]);
      pos = c;
    end
    place(pos, id, key);
  endfunction

  function automatic void settle(int pos, logic [5:0] id, logic [31:0] key);
    int p;
    while (pos > 0) begin
      p = (pos - 1) >> 1;
      if (!(key < heap_key[p])) break;
      place(pos, heap_id[p], heap_key[p]);
      pos = p;
    end
    sink_down(pos, id, key);
  endfunction

  // Apply one operation to the shadow heap and return its result.
  function automatic heap_result_t apply_op(logic [1:0] op, logic [5:0] id,
                                            logic [31:0] key, logic [5:0] old);
    heap_result_t r;
    logic [5:0] tail_id;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (slot_of[id] != POS_NONE) r.status = ST_PRESENT;
        else if (heap_fill >= CAPACITY) r.status = ST_FULL;
        else begin
          heap_fill++;
          settle(heap_fill - 1, id, key);
        end
      end
      OP_REPLACE: begin
        if (slot_of[old] == POS_NONE) r.status = ST_ABSENT;
        else if (slot_of[id] != POS_NONE) r.status = ST_PRESENT;
        else begin
          settle(slot_of[old], id, key);
          slot_of[old] = POS_NONE;
        end
      end
      OP_REMOVE: begin
        if (slot_of[id] == POS_NONE) r.status = ST_ABSENT;
        else begin
          heap_fill--;
          tail_id = heap_id[heap_fill];
          if (tail_id != id) settle(slot_of[id], tail_id, heap_key[heap_fill]);
          slot_of[id] = POS_NONE;
        end
      end
      default: begin
        if (heap_fill == 0) r.status = ST_EMPTY;
        else begin
          r.popped_id = heap_id[0];
          r.popped_key = heap_key[0];
          slot_of[heap_id[0]] = POS_NONE;
          heap_fill--;
          if (heap_fill != 0) sink_down(0, heap_id[heap_fill], heap_key[heap_fill]);
        end
      end
    endcase
    r.front_valid = heap_fill != 0;
    r.front_id = heap_fill != 0 ? heap_id[0] : '0;
    r.front_key = heap_fill != 0 ? heap_key[0] : '0;
    r.entry_count = heap_fill[6:0];
    return r;
  endfunction

  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one transaction and hold it until the unit takes it.
  task automatic send_op(logic [1:0] op, logic [5:0] id, logic [31:0] key,
                         logic [5:0] old);
    in_valid <= 1'b1;
    opcode <= op;
    item_id <= id;
    item_key <= key;
    old_id <= old;
    do @(posedge clk); while (!(in_ready && !timed_out));
    sb.note_input(apply_op(op, id, key, old));
    accepted++;
  endtask

  // Insert a random gap after a transaction, with valid dropped during the gap.
  task automatic pause_source();
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0 && !timed_out) @(posedge clk);
  endtask

  function automatic logic [5:0] pick_present();
    int k;
    k = $urandom_range(0, heap_fill - 1);
    return heap_id[k];
  endfunction

  function automatic logic [5:0] pick_absent();
    logic [5:0] v;
    for (int n = 0; n < 200; n++) begin
      v = $urandom_range(0, 63);
      if (slot_of[v] == POS_NONE) return v;
    end
    return $urandom_range(0, 63);
  endfunction

  function automatic logic [31:0] rand_key();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 7);         // frequent ties
      1: return 32'hffff_ffff - $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  // Receiver: random stalls, a few long ones, with stretches of constant
  // readiness.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_hold <= 0;
    end else begin
      if (out_valid && out_ready)
        sb.check_result({status, popped_id, popped_key, front_valid, front_id,
                         front_key, entry_count});
      if (sink_quiet) begin
        out_ready <= 1'b1;
      end else if (sink_hold > 0) begin
        out_ready <= 1'b0;
        sink_hold <= sink_hold - 1;
      end else if ($urandom_range(0, 99) < 3) begin
        out_ready <= 1'b0;
        sink_hold <= $urandom_range(8, 40);
      end else begin
        out_ready <= ($urandom_range(0, 99) < 60);
      end
    end
  end

  // Watchdog: count cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("indexed_min_heap_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [1:0]  op;
    logic [5:0]  id;
    logic [5:0]  old;
    int          roll;
    sb = new();
    timed_out = 1'b0;
    sink_quiet = 1'b0;
    accepted = 0;
    heap_fill = 0;
    idle_cycles = 0;
    for (int i = 0; i < NUM_IDS; i++) slot_of[i] = POS_NONE;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty-heap errors, key extremes, ties, misuse codes.
    send_op(OP_POP, 6'd0, 32'd0, 6'd0);
    send_op(OP_REMOVE, 6'd63, 32'd0, 6'd0);
    send_op(OP_REPLACE, 6'd1, 32'd5, 6'd2);
    send_op(OP_INSERT, 6'd63, 32'hffff_ffff, 6'd0);
    send_op(OP_INSERT, 6'd0, 32'd0, 6'd63);
    send_op(OP_INSERT, 6'd0, 32'd9, 6'd0);          // id already present
    send_op(OP_INSERT, 6'd5, 32'd0, 6'd0);          // equal key to root
    send_op(OP_INSERT, 6'd6, 32'h5555_aaaa, 6'd0);
    send_op(OP_REPLACE, 6'd7, 32'haaaa_5555, 6'd9); // old id absent
    send_op(OP_REPLACE, 6'd5, 32'd1, 6'd6);         // new id present
    send_op(OP_REPLACE, 6'd6, 32'd1, 6'd6);         // new equals old
    send_op(OP_REPLACE, 6'd42, 32'd3, 6'd6);
    send_op(OP_REMOVE, 6'd63, 32'd0, 6'd0);         // remove last slot
    send_op(OP_REMOVE, 6'd0, 32'd0, 6'd0);          // remove root
    send_op(OP_POP, 6'd0, 32'd0, 6'd0);
    send_op(OP_POP, 6'd0, 32'd0, 6'd0);             // pop last item
    send_op(OP_POP, 6'd0, 32'd0, 6'd0);             // now empty
    // Fill to capacity, then one more with an id already present.
    for (int i = 0; i < NUM_IDS; i++) send_op(OP_INSERT, i[5:0], rand_key(), 6'd0);
    send_op(OP_INSERT, 6'd3, 32'd0, 6'd0);          // present wins over full
    send_op(OP_REMOVE, 6'd17, 32'd0, 6'd0);
    send_op(OP_INSERT, 6'd17, 32'd4, 6'd0);
    wait_drain(); // hold the source until every result is back

    // Random: mostly well-formed operations, some misuse.
    for (int n = 0; n < RANDOM_OPS && !timed_out; n++) begin
      if (n % 400 == 200) sink_quiet = ~sink_quiet;
      if (n == 900) wait_drain();
      roll = $urandom_range(0, 99);
      old = $urandom_range(0, 63);
      id = $urandom_range(0, 63);
      if (roll < 10) begin
        op = $urandom_range(0, 3); // noise
      end else if (heap_fill == 0 || (heap_fill < 48 && roll < 45)) begin
        op = OP_INSERT; id = pick_absent();
      end else if (roll < 62) begin
        op = OP_REPLACE; old = pick_present(); id = pick_absent();
      end else if (roll < 80) begin
        op = OP_REMOVE; id = pick_present();
      end else if (roll < 92 || heap_fill >= 48) begin
        op = OP_POP;
      end else begin
        op = OP_INSERT; id = pick_absent();
      end
      send_op(op, id, rand_key(), old);
      pause_source();
    end
    wait_drain();
    repeat (50) @(posedge clk);

    $display("covered %0d transactions, %0d results checked", accepted, sb.checked);
    $display("ops: insert/replace/remove/pop, empty and full heap, key ties");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("indexed_min_heap_unit regression: pass");
    end else begin
      $display("indexed_min_heap_unit regression: fail");
    end
    $finish;
  end
endmodule

[indexed_min_heap_unit.f]
+incdir+sv
sv/imh_pkg.sv
sv/imh_ram.sv
sv/imh_posmap.sv
sv/indexed_min_heap_unit.sv
sv/imh_checker.sv
bench/indexed_min_heap_unit_tb.sv
